### rtl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg: shared types and constants for the keyframe time interpolator
// Request codes, status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int MaxPointsDef  = 1024;
  localparam int CoordWidthDef = 16;
  localparam int TimeWidthDef  = 24;
  localparam int IdxW          = 10;
  localparam int StrokeW       = 8;
  localparam int FracW         = 16;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_LAST_CK, S_SCAN_CK, S_PREV_CK, S_DIV, S_MUL, S_SUM, S_EMIT
  } kti_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;        // capture the transaction and preset the result
    logic do_append;     // write the captured point
    logic do_clear;      // reset point count
    logic rd_last;       // read entry count-1
    logic ld_last;       // result is the last entry
    logic scan_rd;       // read the first scan entry
    logic scan_inc;      // advance scan index and read it
    logic ld_found;      // capture the found entry
    logic rd_prev;       // read the entry before the found one
    logic ld_prev;       // capture the predecessor and start the divider
    logic div_step;      // one division iteration
    logic mul;           // multiply stage
    logic sum;           // finish mix
    logic emit;          // present result
  } kti_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic empty;
    logic full;
    logic q_ge_last;   // query at/after last point
    logic scan_hit;    // scanned time greater than query, or end of scan
    logic direct;      // found entry is first of the store or of its stroke
    logic div_done;
  } kti_sts_t;

endpackage

### rtl/keyframe_time_interpolator_unit.sv
// Clear, append and unused requests go straight to the result strobe; a query on a non-empty
// store checks the last entry, then scans one point per cycle, and an interpolated point goes
// on through a 16-step divider, a multiply stage and a sum stage before the strobe.
// One request at a time; busy is high while the controller is out of idle, up to the cycle before the strobe.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the point store; RAM contents are kept.
// ----------------------------------------------------------------------------
// keyframe_time_interpolator_unit: top level
// Controller plus datapath for the keyframe interpolator.
// ----------------------------------------------------------------------------
module keyframe_time_interpolator_unit #(
  parameter int MaxPoints  = kti_pkg::MaxPointsDef,
  parameter int CoordWidth = kti_pkg::CoordWidthDef,
  parameter int TimeWidth  = kti_pkg::TimeWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_req_type,
  input  logic [7:0]                   in_stroke_id,
  input  logic [TimeWidth-1:0]         in_point_time,
  input  logic [TimeWidth-1:0]         in_query_time,
  input  logic signed [CoordWidth-1:0] in_pos_x,
  input  logic signed [CoordWidth-1:0] in_pos_y,
  input  logic signed [CoordWidth-1:0] in_pos_z,
  input  logic [15:0]                  in_dist_in,
  input  logic signed [15:0]           in_angle_in,
  output logic                         out_valid,
  output logic signed [CoordWidth-1:0] out_x,
  output logic signed [CoordWidth-1:0] out_y,
  output logic signed [CoordWidth-1:0] out_z,
  output logic [15:0]                  out_dist,
  output logic signed [15:0]           out_angle,
  output logic [7:0]                   out_stroke,
  output logic [9:0]                   out_index,
  output logic                         out_done_res,
  output logic [1:0]                   out_status
);
  import kti_pkg::*;

  kti_cmd_t cmd;
  kti_sts_t sts;

  kti_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req(in_req_type),
    .sts(sts), .busy(busy), .cmd(cmd));

  kti_dp #(.MaxPoints(MaxPoints), .CoordWidth(CoordWidth), .TimeWidth(TimeWidth)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req_type(in_req_type), .in_stroke_id(in_stroke_id),
    .in_point_time(in_point_time), .in_query_time(in_query_time),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_dist_in(in_dist_in), .in_angle_in(in_angle_in), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_dist(out_dist), .out_angle(out_angle), .out_stroke(out_stroke),
    .out_index(out_index), .out_done_res(out_done_res), .out_status(out_status));
endmodule

### rtl/kti_ram.sv
// ----------------------------------------------------------------------------
// kti_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module kti_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/kti_ctrl.sv
// ----------------------------------------------------------------------------
// kti_ctrl: controller for the keyframe time interpolator
// Sequences append, clear and query through the datapath.
// ----------------------------------------------------------------------------
module kti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        req,
  input  kti_pkg::kti_sts_t sts,
  output logic              busy,
  output kti_pkg::kti_cmd_t cmd
);
  import kti_pkg::*;

  kti_state_t state_r, state_nxt;
  logic       acc;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) state_nxt = (req == REQ_QUERY && !sts.empty) ? S_LAST_CK : S_EMIT;
      end
      S_LAST_CK: state_nxt = sts.q_ge_last ? S_EMIT : S_SCAN_CK;
      S_SCAN_CK: begin
        if (sts.scan_hit) state_nxt = sts.direct ? S_EMIT : S_PREV_CK;
      end
      S_PREV_CK: state_nxt = S_DIV;
      S_DIV:     if (sts.div_done) state_nxt = S_MUL;
      S_MUL:     state_nxt = S_SUM;
      S_SUM:     state_nxt = S_EMIT;
      S_EMIT:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept    = acc;
        cmd.do_append = acc && req == REQ_APPEND && !sts.full;
        cmd.do_clear  = acc && req == REQ_CLEAR;
        cmd.rd_last   = acc && req == REQ_QUERY;
      end
      S_LAST_CK: begin
        cmd.ld_last = sts.q_ge_last;
        cmd.scan_rd = !sts.q_ge_last;
      end
      S_SCAN_CK: begin
        cmd.scan_inc = !sts.scan_hit;
        cmd.ld_found = sts.scan_hit;
        cmd.rd_prev  = sts.scan_hit && !sts.direct;
      end
      S_PREV_CK: cmd.ld_prev = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_MUL:     cmd.mul = 1'b1;
      S_SUM:     cmd.sum = 1'b1;
      S_EMIT:    cmd.emit = 1'b1;
      default:   cmd = '0;
    endcase
  end

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |=> state_r == S_IDLE) else $error("emit not followed by idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.accept) else $error("accept while busy");
  a_div_after_prev: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PREV_CK |=> state_r == S_DIV) else $error("division not started");
  a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_last, cmd.scan_rd, cmd.scan_inc, cmd.rd_prev}))
    else $error("conflicting reads");
endmodule

### rtl/kti_dp.sv
// ----------------------------------------------------------------------------
// kti_dp: datapath for the keyframe time interpolator
// Point store, scan, serial fraction divider and linear mix.
// ----------------------------------------------------------------------------
module kti_dp #(
  parameter int MaxPoints  = kti_pkg::MaxPointsDef,
  parameter int CoordWidth = kti_pkg::CoordWidthDef,
  parameter int TimeWidth  = kti_pkg::TimeWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_req_type,
  input  logic [7:0]                   in_stroke_id,
  input  logic [TimeWidth-1:0]         in_point_time,
  input  logic [TimeWidth-1:0]         in_query_time,
  input  logic signed [CoordWidth-1:0] in_pos_x,
  input  logic signed [CoordWidth-1:0] in_pos_y,
  input  logic signed [CoordWidth-1:0] in_pos_z,
  input  logic [15:0]                  in_dist_in,
  input  logic signed [15:0]           in_angle_in,
  input  kti_pkg::kti_cmd_t            cmd,
  output kti_pkg::kti_sts_t            sts,
  output logic                         out_valid,
  output logic signed [CoordWidth-1:0] out_x,
  output logic signed [CoordWidth-1:0] out_y,
  output logic signed [CoordWidth-1:0] out_z,
  output logic [15:0]                  out_dist,
  output logic signed [15:0]           out_angle,
  output logic [7:0]                   out_stroke,
  output logic [9:0]                   out_index,
  output logic                         out_done_res,
  output logic [1:0]                   out_status
);
  import kti_pkg::*;

  localparam int AW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int EW = TimeWidth + 3 * CoordWidth + 32 + StrokeW + IdxW;
  localparam int NV = 5;
  localparam int VW = ((CoordWidth > 16) ? CoordWidth : 16) + 1;
  localparam int PW = VW + FracW + 2;

  logic [CW-1:0]                count_r;
  logic [IdxW-1:0]              pis_r;
  logic [StrokeW-1:0]           last_sid_r;
  logic [TimeWidth-1:0]         q_r;
  logic [AW-1:0]                scan_r, addr, last_a;
  logic [EW-1:0]                wdata, rdata;
  logic [IdxW-1:0]              new_idx;

  // fields of the entry read last cycle
  logic [TimeWidth-1:0]         r_time;
  logic signed [CoordWidth-1:0] r_x, r_y, r_z;
  logic [15:0]                  r_dist;
  logic signed [15:0]           r_angle;
  logic [StrokeW-1:0]           r_sid;
  logic [IdxW-1:0]              r_idx;
  logic signed [VW-1:0]         r_val [NV];

  logic [TimeWidth-1:0]         tb_r, den_r, rem_r;
  logic [FracW-1:0]             f_r;
  logic [4:0]                   dcnt_r;
  logic [TimeWidth+1:0]         trial;
  logic                         frac_ok;
  logic signed [VW-1:0]         a_r [NV];
  logic signed [VW-1:0]         b_r [NV];
  logic signed [VW:0]           diff [NV];
  logic signed [PW-1:0]         prod_r [NV];
  logic signed [VW-1:0]         mix_val [NV];

  assign new_idx = (count_r == '0 || last_sid_r != in_stroke_id) ? '0 : pis_r;
  assign wdata = {in_point_time, in_pos_x, in_pos_y, in_pos_z, in_dist_in, in_angle_in,
                  in_stroke_id, new_idx};
  assign {r_time, r_x, r_y, r_z, r_dist, r_angle, r_sid, r_idx} = rdata;

  always_comb begin
    r_val[0] = VW'(r_x);
    r_val[1] = VW'(r_y);
    r_val[2] = VW'(r_z);
    r_val[3] = VW'(r_dist);
    r_val[4] = VW'(r_angle);
  end

  assign last_a = AW'(count_r - CW'(1));

  always_comb begin
    addr = AW'(count_r);
    if (cmd.rd_last) addr = last_a;
    else if (cmd.scan_inc) addr = scan_r + AW'(1);
    else if (cmd.rd_prev) addr = scan_r - AW'(1);
    else if (cmd.scan_rd) addr = scan_r;
  end

  kti_ram #(.Width(EW), .Depth(MaxPoints)) u_ram (
    .clk(clk), .we(cmd.do_append), .addr(addr), .wdata(wdata), .rdata(rdata));

  always_comb begin
    sts.empty     = (count_r == '0);
    sts.full      = (count_r == CW'(MaxPoints));
    sts.q_ge_last = (q_r >= r_time);
    sts.scan_hit  = (r_time > q_r) || (scan_r == last_a);
    sts.direct    = (scan_r == '0) || (r_idx == '0);
    sts.div_done  = (dcnt_r == '0);
  end

  // The remainder starts below the divisor, so sixteen steps give the whole fraction.
  assign frac_ok = (q_r > r_time) && (tb_r > r_time);
  assign trial = {1'b0, rem_r, 1'b0} - {2'b00, den_r};

  always_comb begin
    for (int k = 0; k < NV; k++) begin
      diff[k]    = (VW+1)'(b_r[k]) - (VW+1)'(a_r[k]);
      mix_val[k] = a_r[k] + VW'((prod_r[k] + PW'(32'sd32768)) >>> FracW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pis_r <= '0;
      out_valid <= 1'b0;
      dcnt_r <= '0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.do_clear) begin
        count_r <= '0;
        pis_r <= '0;
      end
      if (cmd.do_append) begin
        count_r <= count_r + CW'(1);
        pis_r <= new_idx + IdxW'(1);
      end
      if (cmd.ld_prev) dcnt_r <= 5'(FracW);
      else if (cmd.div_step && dcnt_r != '0) dcnt_r <= dcnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_append) last_sid_r <= in_stroke_id;
    if (cmd.accept) begin
      q_r <= in_query_time;
      scan_r <= '0;
      out_x <= '0;
      out_y <= '0;
      out_z <= '0;
      out_dist <= '0;
      out_angle <= '0;
      out_stroke <= '0;
      out_index <= '0;
      out_done_res <= 1'b0;
      if (in_req_type == REQ_APPEND && sts.full) out_status <= ST_FULL;
      else if (in_req_type == REQ_QUERY && sts.empty) out_status <= ST_EMPTY;
      else out_status <= ST_OK;
    end
    if (cmd.scan_inc) scan_r <= scan_r + AW'(1);
    if (cmd.ld_last || cmd.ld_found) begin
      out_x <= r_x;
      out_y <= r_y;
      out_z <= r_z;
      out_dist <= r_dist;
      out_angle <= r_angle;
      out_stroke <= r_sid;
      out_index <= r_idx;
      out_done_res <= cmd.ld_last;
    end
    if (cmd.ld_found) begin
      tb_r <= r_time;
      for (int k = 0; k < NV; k++) b_r[k] <= r_val[k];
    end
    if (cmd.ld_prev) begin
      for (int k = 0; k < NV; k++) a_r[k] <= r_val[k];
      // An all-ones divisor with a zero remainder yields a zero fraction.
      den_r <= frac_ok ? tb_r - r_time : '1;
      rem_r <= frac_ok ? q_r - r_time : '0;
      f_r <= '0;
    end
    if (cmd.div_step && dcnt_r != '0) begin
      if (!trial[TimeWidth+1]) rem_r <= trial[TimeWidth-1:0];
      else rem_r <= {rem_r[TimeWidth-2:0], 1'b0};
      f_r <= {f_r[FracW-2:0], !trial[TimeWidth+1]};
    end
    if (cmd.mul)
      for (int k = 0; k < NV; k++)
        prod_r[k] <= PW'(diff[k]) * PW'($signed({1'b0, f_r}));
    if (cmd.sum) begin
      out_x <= CoordWidth'(mix_val[0]);
      out_y <= CoordWidth'(mix_val[1]);
      out_z <= CoordWidth'(mix_val[2]);
      out_dist <= 16'(mix_val[3]);
      out_angle <= 16'(mix_val[4]);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MaxPoints)) else $error("point count overflow");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_clear |=> count_r == '0) else $error("clear failed");
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_append |=> count_r == $past(count_r) + CW'(1)) else $error("append count");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
endmodule
